>>> src/out_bounce_ease_interpolator_macros.svh
// Assertion shorthands; clk and rst_n must be in scope where used.
`ifndef OUT_BOUNCE_EASE_INTERPOLATOR_MACROS_SVH
`define OUT_BOUNCE_EASE_INTERPOLATOR_MACROS_SVH

// cons must hold in the same cycle as ante
`define OBE_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obe: same-cycle check failed");

// cons must hold in the cycle after ante
`define OBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obe: next-cycle check failed");

`endif

>>> src/obe_pkg.sv
package obe_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 32;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // sideband that rides along each pipeline stage
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [VAL_W-1:0] start_val;
    logic signed [VAL_W-1:0] end_val;
  } obe_tag_t;

endpackage

>>> src/obe_div.sv
module obe_div #(
  parameter int TIME_BITS = obe_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = obe_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TIME_BITS-1:0] el_i,
  input  logic [TIME_BITS-1:0] tot_i,
  input  obe_pkg::obe_tag_t    tag_i,
  output logic [FRAC_BITS:0]   t_o,
  output obe_pkg::obe_tag_t    tag_o
);
  import obe_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int F  = FRAC_BITS;
  localparam int WW = F + 1;
  localparam logic [F:0] ONE_W = WW'(1) << F;

  // one quotient bit per stage, restoring division
  logic [TB-1:0] rem_r [0:F];
  logic [TB-1:0] den_r [0:F];
  logic [F-1:0]  quo_r [0:F];
  logic          one_r [0:F];
  obe_tag_t      tag_r [0:F];

  logic sat_in;
  assign sat_in = (tot_i == '0) || (el_i >= tot_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0].valid <= 1'b0;
    end else begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= tot_i;
    one_r[0] <= sat_in;
    rem_r[0] <= sat_in ? '0 : el_i;
    quo_r[0] <= '0;
  end

  for (genvar i = 1; i <= F; i++) begin : g_step
    logic [TB:0]   sh;
    logic [TB+1:0] dif;
    logic          take;
    logic [TB-1:0] rem_nxt;

    always_comb begin
      sh      = {rem_r[i-1], 1'b0};
      dif     = {1'b0, sh} - {2'b00, den_r[i-1]};
      take    = !dif[TB+1];
      rem_nxt = take ? dif[TB-1:0] : sh[TB-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i].valid <= 1'b0;
      end else begin
        tag_r[i] <= tag_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_r[i-1];
      quo_r[i] <= {quo_r[i-1][F-2:0], take};
      one_r[i] <= one_r[i-1];
    end
  end

  assign t_o   = one_r[F] ? ONE_W : {1'b0, quo_r[F]};
  assign tag_o = tag_r[F];

endmodule

>>> src/obe_curve.sv
module obe_curve #(
  parameter int FRAC_BITS = obe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FRAC_BITS:0] t_i,
  input  obe_pkg::obe_tag_t  tag_i,
  output logic [FRAC_BITS:0] w_o,
  output obe_pkg::obe_tag_t  tag_o
);
  import obe_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int WW   = F + 1;
  localparam int SW   = F + 5;      // 2.75*t with F+2 fraction bits
  localparam int DW   = F + 2;      // distance from segment center
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 1;

  localparam logic [SW-1:0] S_ONE  = SW'(1) << (F + 2);
  localparam logic [SW-1:0] S_TWO  = SW'(2) << (F + 2);
  localparam logic [SW-1:0] S_2P5  = SW'(5) << (F + 1);
  localparam logic [SW-1:0] K_1P5  = SW'(3) << (F + 1);
  localparam logic [SW-1:0] K_2P25 = SW'(9) << F;
  localparam logic [SW-1:0] K_2P62 = SW'(21) << (F - 1);

  localparam logic [F:0] ONE_W  = WW'(1) << F;
  localparam logic [F:0] C_0P75 = WW'(3) << (F - 2);
  localparam logic [F:0] C_0P94 = WW'(15) << (F - 4);
  localparam logic [F:0] C_0P98 = WW'(63) << (F - 6);

  localparam logic [SUMW-1:0] RND = SUMW'(1) << (F + 3);

  obe_tag_t tag_r [0:3];

  logic [SW-1:0]  s_r, s_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [F:0]     c1_r, c_nxt, c2_r;
  logic [SQW-1:0] sq_r, sq_nxt;
  logic [F:0]     w_r, w_nxt;

  // stage 0: s = 11*t
  assign s_nxt = {1'b0, t_i, 3'b000} + {3'b000, t_i, 1'b0} + {4'b0000, t_i};

  // stage 1: segment pick and distance
  logic [SW-1:0] kk, dd;
  always_comb begin
    if (s_r < S_ONE) begin
      kk    = '0;
      c_nxt = '0;
    end else if (s_r < S_TWO) begin
      kk    = K_1P5;
      c_nxt = C_0P75;
    end else if (s_r < S_2P5) begin
      kk    = K_2P25;
      c_nxt = C_0P94;
    end else begin
      kk    = K_2P62;
      c_nxt = C_0P98;
    end
    dd    = (s_r >= kk) ? (s_r - kk) : (kk - s_r);
    d_nxt = dd[DW-1:0];
  end

  // stage 2: square
  assign sq_nxt = d_r * d_r;

  // stage 3: round to F bits, add offset, limit to one
  logic [SUMW-1:0] sq_rnd;
  logic [F+1:0]    wc;
  always_comb begin
    sq_rnd = {1'b0, sq_r} + RND;
    wc     = {1'b0, sq_rnd[SUMW-1:F+4]} + {1'b0, c2_r};
    w_nxt  = (wc > {1'b0, ONE_W}) ? ONE_W : wc[F:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0].valid <= 1'b0;
      tag_r[1].valid <= 1'b0;
      tag_r[2].valid <= 1'b0;
      tag_r[3].valid <= 1'b0;
    end else begin
      tag_r[0] <= tag_i;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
      tag_r[3] <= tag_r[2];
    end
  end

  always_ff @(posedge clk) begin
    s_r  <= s_nxt;
    d_r  <= d_nxt;
    c1_r <= c_nxt;
    sq_r <= sq_nxt;
    c2_r <= c1_r;
    w_r  <= w_nxt;
  end

  assign w_o   = w_r;
  assign tag_o = tag_r[3];

endmodule

>>> src/obe_blend.sv
`include "out_bounce_ease_interpolator_macros.svh"

module obe_blend #(
  parameter int FRAC_BITS = obe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [FRAC_BITS:0]               w_i,
  input  obe_pkg::obe_tag_t                tag_i,
  output logic                             out_vld_o,
  output logic signed [obe_pkg::VAL_W-1:0] out_val_o,
  output logic                             out_zero_o,
  output logic                             out_sat_o
);
  import obe_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int WW = F + 1;
  localparam int DFW = VAL_W + 1;          // end - start
  localparam int PW = DFW + F + 2;         // signed product
  localparam int MW = PW - F;              // rounded magnitude
  localparam int RW = VAL_W + 4;           // sum before clipping

  localparam logic [F:0]    ONE_W = WW'(1) << F;
  localparam logic [PW-1:0] HALF  = PW'(1) << (F - 1);

  obe_tag_t tag_r [0:2];

  logic signed [DFW-1:0] diff_r, diff_nxt;
  logic [F:0]            w_r;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic [MW-1:0]         rmag_r, rmag_nxt;
  logic                  neg_r;

  logic                    out_vld_r;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic                    out_zero_r;
  logic                    out_sat_r, out_sat_nxt;

  // b0: span
  assign diff_nxt = DFW'(tag_i.end_val) - DFW'(tag_i.start_val);

  // b1: weighted span
  assign prod_nxt = diff_r * $signed({1'b0, w_r});

  // b2: magnitude, round half away from zero
  logic [PW-1:0] mag, msum;
  always_comb begin
    mag      = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    msum     = mag + HALF;
    rmag_nxt = msum[PW-1:F];
  end

  // b3: add to start, clip
  logic signed [RW-1:0] res, step;
  logic                 hi, lo;
  always_comb begin
    step = neg_r ? -RW'({1'b0, rmag_r}) : RW'({1'b0, rmag_r});
    res  = RW'(tag_r[2].start_val) + step;
    hi   = !res[RW-1] && (res[RW-2:VAL_W-1] != '0);
    lo   = res[RW-1] && (res[RW-2:VAL_W-1] != '1);
    out_sat_nxt = hi || lo;
    if (hi) begin
      out_val_nxt = VAL_MAX;
    end else if (lo) begin
      out_val_nxt = VAL_MIN;
    end else begin
      out_val_nxt = res[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0].valid <= 1'b0;
      tag_r[1].valid <= 1'b0;
      tag_r[2].valid <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      tag_r[0]  <= tag_i;
      tag_r[1]  <= tag_r[0];
      tag_r[2]  <= tag_r[1];
      out_vld_r <= tag_r[2].valid;
    end
  end

  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    w_r        <= w_i;
    prod_r     <= prod_nxt;
    rmag_r     <= rmag_nxt;
    neg_r      <= prod_r[PW-1];
    out_val_r  <= out_val_nxt;
    out_zero_r <= tag_r[2].zero;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_vld_o  = out_vld_r;
  assign out_val_o  = out_val_r;
  assign out_zero_o = out_zero_r;
  assign out_sat_o  = out_sat_r;

  // weight never exceeds one, so the result stays between start and end
  `OBE_ASSERT_HOLDS(a_weight_le_one, tag_i.valid, w_i <= ONE_W)
  `OBE_ASSERT_HOLDS(a_no_clip, out_vld_r, !out_sat_r)
  `OBE_ASSERT_NEXT(a_zero_gives_end, tag_r[2].valid && tag_r[2].zero, out_val_r == $past(tag_r[2].end_val))

endmodule

>>> src/out_bounce_ease_interpolator.sv
// Channel   Ports                                        Handshake
// -------   -------------------------------------------  ------------------------------
// input     in_elapsed_time, in_total_time,              beat taken when start && !busy
//           in_start_value, in_end_value
// result    out_eased_value, out_zero_duration,          one beat per out_strobe cycle
//           out_saturated
//
// Throughput: one beat per clock; busy is always low.
// Path from start to out_strobe: the divider, one quotient bit per stage,
//   then 4 curve and 4 blend stages.
// Reset (rst_n low, synchronous) clears every stage valid bit; data regs are not reset.
// The receiver cannot stall, so the pipeline never holds; every beat emerges once.
module out_bounce_ease_interpolator #(
  parameter int TIME_BITS = obe_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = obe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [TIME_BITS-1:0]             in_elapsed_time,
  input  logic [TIME_BITS-1:0]             in_total_time,
  input  logic signed [obe_pkg::VAL_W-1:0] in_start_value,
  input  logic signed [obe_pkg::VAL_W-1:0] in_end_value,
  output logic                             out_strobe,
  output logic signed [obe_pkg::VAL_W-1:0] out_eased_value,
  output logic                             out_zero_duration,
  output logic                             out_saturated
);
  import obe_pkg::*;

  obe_tag_t          in_tag;
  logic [FRAC_BITS:0] t_div;
  obe_tag_t          tag_div;
  logic [FRAC_BITS:0] w_crv;
  obe_tag_t          tag_crv;

  // fully pipelined, a new beat may enter every cycle
  assign busy = 1'b0;

  // sideband: valid, zero-duration flag and the endpoints follow the ratio
  always_comb begin
    in_tag.valid     = start && !busy;
    in_tag.zero      = (in_total_time == '0);
    in_tag.start_val = in_start_value;
    in_tag.end_val   = in_end_value;
  end

  // ratio elapsed/total as Q1.F, clamped to one
  obe_div #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .el_i  (in_elapsed_time),
    .tot_i (in_total_time),
    .tag_i (in_tag),
    .t_o   (t_div),
    .tag_o (tag_div)
  );

  // four-segment out-bounce weight
  obe_curve #(
    .FRAC_BITS(FRAC_BITS)
  ) u_curve (
    .clk   (clk),
    .rst_n (rst_n),
    .t_i   (t_div),
    .tag_i (tag_div),
    .w_o   (w_crv),
    .tag_o (tag_crv)
  );

  // start + w*(end-start), rounded and clipped
  obe_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .w_i        (w_crv),
    .tag_i      (tag_crv),
    .out_vld_o  (out_strobe),
    .out_val_o  (out_eased_value),
    .out_zero_o (out_zero_duration),
    .out_sat_o  (out_saturated)
  );

endmodule
